// File: rtl/rmst_pkg.sv
// Shared types, constants and request codes for the range minimum segment tree.
`timescale 1ns / 1ps
package rmst_pkg;

    localparam int RMST_LEAVES = 128;
    localparam int VAL_W       = 32;

    localparam logic signed [VAL_W-1:0] VAL_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] RESET_FILL = 32'sh7FFF_FFFF;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic clr_boot;
        logic upd_write;
        logic upd_fold;
        logic q_step;
        logic root_read;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       k_root;
        logic       q_lt;
        logic       q_err;
        logic       q_full;
        logic       q_empty;
        logic       out_free;
        logic [1:0] req_type;
    } t_stat;

endpackage

// File: rtl/rmst_req_if.sv
// Request channel: one word per tree operation.
`timescale 1ns / 1ps
interface rmst_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [6:0]        leaf_index;
    logic signed [31:0] leaf_value;
    logic [7:0]        range_lo;
    logic [7:0]        range_hi;

    modport source (output valid, req_type, leaf_index, leaf_value, range_lo, range_hi,
                    input ready);
    modport sink   (input valid, req_type, leaf_index, leaf_value, range_lo, range_hi,
                    output ready);
endinterface

// File: rtl/rmst_rsp_if.sv
// Response channel: one word per request.
`timescale 1ns / 1ps
interface rmst_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] min_value;
    logic               range_error;

    modport source (output valid, min_value, range_error, input ready);
    modport sink   (input valid, min_value, range_error, output ready);
endinterface

// File: rtl/rmst_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 255,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/rmst_ctrl.sv
// Controller state machine sequencing clear sweeps, leaf updates and range queries.
`timescale 1ns / 1ps
module rmst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  rmst_pkg::t_stat i_stat,
    output rmst_pkg::t_cmd  o_cmd
);
    import rmst_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_UW   = 3'd3;
    localparam logic [2:0] S_UF   = 3'd4;
    localparam logic [2:0] S_QS   = 3'd5;
    localparam logic [2:0] S_QD   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_boot, n_boot;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_boot  = r_boot;
        cmd     = '0;
        cmd.clr_boot = r_boot;
        case (r_state)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_boot ? S_IDLE : S_FIN;
                    n_boot  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.req_type)
                    REQ_UPDATE: n_state = S_UW;
                    REQ_QUERY: begin
                        if (i_stat.q_err || i_stat.q_empty) begin
                            n_state = S_FIN;
                        end else if (i_stat.q_full) begin
                            cmd.root_read = 1'b1;
                            n_state       = S_QD;
                        end else begin
                            n_state = S_QS;
                        end
                    end
                    REQ_CLEAR: n_state = S_CLR;
                    default:   n_state = S_FIN;
                endcase
            end
            S_UW: begin
                cmd.upd_write = 1'b1;
                n_state = i_stat.k_root ? S_FIN : S_UF;
            end
            S_UF: begin
                cmd.upd_fold = 1'b1;
                n_state      = S_UW;
            end
            S_QS: begin
                if (i_stat.q_lt) begin
                    cmd.q_step = 1'b1;
                end else begin
                    n_state = S_QD;
                end
            end
            S_QD: n_state = S_FIN;
            S_FIN: begin
                if (i_stat.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
        end
    end

    assign o_cmd       = cmd;
    assign o_req_ready = (r_state == S_IDLE);
endmodule

// File: rtl/rmst_dp.sv
// Datapath: tree memory, walk pointers, running minimum and response register.
`timescale 1ns / 1ps
module rmst_dp #(
    parameter int LEAVES = rmst_pkg::RMST_LEAVES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rmst_pkg::t_cmd     i_cmd,
    output rmst_pkg::t_stat    o_stat,
    input  logic [1:0]         i_req_type,
    input  logic [6:0]         i_leaf_index,
    input  logic signed [31:0] i_leaf_value,
    input  logic [7:0]         i_range_lo,
    input  logic [7:0]         i_range_hi,
    input  logic signed [31:0] i_fill,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_min_value,
    output logic               o_range_error
);
    import rmst_pkg::*;

    localparam int LW    = $clog2(LEAVES);
    localparam int AW    = LW + 1;
    localparam int NW    = LW + 2;
    localparam int DEPTH = 2 * LEAVES - 1;
    localparam int EW    = (NW > 8) ? NW : 8;

    // Node pointers are 1-based heap indexes; memory address is index minus one.
    logic [1:0]              r_type;
    logic                    r_err, r_full, r_empty;
    logic [NW-1:0]           r_l, r_r;
    logic [AW-1:0]           r_k;
    logic signed [VAL_W-1:0] r_cur, r_acc;
    logic                    r_pend;
    logic [AW-1:0]           r_cnt;
    logic                    r_ov;
    logic signed [VAL_W-1:0] r_min;
    logic                    r_rerr;

    logic [EW-1:0]           lo_e, hi_e, n_e, hi_c, idx_e;
    logic                    c_full, c_empty;
    logic                    we, re, q_read;
    logic [AW-1:0]           waddr, raddr;
    logic signed [VAL_W-1:0] wdata, rdata;

    assign lo_e    = EW'(i_range_lo);
    assign hi_e    = EW'(i_range_hi);
    assign n_e     = EW'(LEAVES);
    assign idx_e   = EW'(i_leaf_index);
    assign hi_c    = (hi_e > n_e) ? n_e : hi_e;
    assign c_full  = (lo_e == '0) && (hi_e >= n_e);
    assign c_empty = (lo_e == hi_e) || (lo_e >= n_e);

    always_comb begin
        we     = 1'b0;
        waddr  = r_k - AW'(1);
        wdata  = r_cur;
        re     = 1'b0;
        raddr  = (r_k ^ AW'(1)) - AW'(1);
        q_read = 1'b0;
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = i_cmd.clr_boot ? RESET_FILL : i_fill;
        end
        if (i_cmd.upd_write) begin
            we = 1'b1;
            re = (r_k != AW'(1));
        end
        if (i_cmd.root_read) begin
            re     = 1'b1;
            q_read = 1'b1;
            raddr  = '0;
        end
        if (i_cmd.q_step) begin
            if (r_l[0]) begin
                re     = 1'b1;
                q_read = 1'b1;
                raddr  = AW'(r_l - NW'(1));
            end else if (r_r[0]) begin
                re     = 1'b1;
                q_read = 1'b1;
                raddr  = AW'(r_r - NW'(2));
            end
        end
    end

    rmst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_pend <= q_read;
            if (i_cmd.capture) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type  <= i_req_type;
            r_err   <= i_range_lo > i_range_hi;
            r_full  <= c_full;
            r_empty <= c_empty;
            r_l     <= lo_e[NW-1:0] + NW'(LEAVES);
            r_r     <= hi_c[NW-1:0] + NW'(LEAVES);
            r_k     <= {1'b1, idx_e[LW-1:0]};
            r_cur   <= i_leaf_value;
            // A full range takes the root alone, so the fill value must not enter.
            r_acc   <= c_full ? VAL_MAX : i_fill;
        end
        if (i_cmd.upd_fold) begin
            r_cur <= (rdata < r_cur) ? rdata : r_cur;
            r_k   <= r_k >> 1;
        end
        if (i_cmd.q_step) begin
            if (r_l[0]) begin
                r_l <= r_l + NW'(1);
            end else if (r_r[0]) begin
                r_r <= r_r - NW'(1);
            end else begin
                r_l <= r_l >> 1;
                r_r <= r_r >> 1;
            end
        end
        if (r_pend && (rdata < r_acc)) begin
            r_acc <= rdata;
        end
        if (i_cmd.load_out) begin
            r_rerr <= (r_type == REQ_QUERY) && r_err;
            r_min  <= ((r_type == REQ_QUERY) && !r_err) ? r_acc : '0;
        end
    end

    assign o_stat.clr_last = (r_cnt == AW'(DEPTH - 1));
    assign o_stat.k_root   = (r_k == AW'(1));
    assign o_stat.q_lt     = (r_l < r_r);
    assign o_stat.q_err    = r_err;
    assign o_stat.q_full   = r_full;
    assign o_stat.q_empty  = r_empty;
    assign o_stat.out_free = !r_ov || i_out_ready;
    assign o_stat.req_type = r_type;

    assign o_out_valid   = r_ov;
    assign o_min_value   = r_min;
    assign o_range_error = r_rerr;
endmodule

// File: rtl/range_min_segment_tree_unit.sv
// Top level of the range minimum segment tree unit.
//
//   port       dir    handshake           word
//   i_req      in     valid/ready         req_type, leaf_index, leaf_value, range_lo, range_hi
//   o_rsp      out    valid/ready         min_value, range_error
//   apb        in     psel/penable        fill_value at byte address 0
//
// One request is in work at a time; the single-port-read tree memory sets the pace.
// Update: one write and one sibling read per level below the root, then a write at the root.
// Query: up to two node reads and one shift per level.
// Clear: one node per cycle; the same sweep runs after reset before the first
// request is taken.
// A waiting response does not block the next request; it only holds the finish step.
`timescale 1ns / 1ps
module range_min_segment_tree_unit #(
    parameter int LEAVES = rmst_pkg::RMST_LEAVES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmst_req_if.sink    i_req,
    rmst_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rmst_pkg::*;

    localparam logic ADDR_FILL = 1'b0;

    t_cmd                    cmd;
    t_stat                   stat;
    logic signed [VAL_W-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= RESET_FILL;
        end else if (psel && penable && pwrite && (paddr[2] == ADDR_FILL)) begin
            r_fill <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_FILL) ? r_fill : '0;

    rmst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rmst_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req.req_type),
        .i_leaf_index  (i_req.leaf_index),
        .i_leaf_value  (i_req.leaf_value),
        .i_range_lo    (i_req.range_lo),
        .i_range_hi    (i_req.range_hi),
        .i_fill        (r_fill),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_min_value   (o_rsp.min_value),
        .o_range_error (o_rsp.range_error)
    );
endmodule

// File: rtl/rmst_chk.sv
// Port-level checker for the range minimum segment tree unit, bound to the top level.
`timescale 1ns / 1ps
module rmst_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_min_value,
    input logic        i_range_error
);
    // The reset sweep keeps requests out.
    a_boot_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_req_ready)
        else $error("request ready right after reset");

    // One request at a time: a taken word drops ready on the next cycle.
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("ready stayed high after a request was taken");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_range_error) |-> (i_min_value == 32'd0))
        else $error("range error word carries a nonzero minimum");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response word dropped while stalled");
endmodule

bind range_min_segment_tree_unit rmst_chk u_rmst_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_min_value   (o_rsp.min_value),
    .i_range_error (o_rsp.range_error)
);

// File: sim/tb_top.sv
// Self-checking testbench for the range minimum segment tree unit.
`timescale 1ns / 1ps
module tb_top;
    import rmst_pkg::*;

    localparam int NODE_CNT = 2 * RMST_LEAVES - 1;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_FILL  = 3'd0;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic               range_error;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rmst_req_if req_bus ();
    rmst_rsp_if rsp_bus ();

    range_min_segment_tree_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_bus.sink), .o_rsp(rsp_bus.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the tree and the fill register.
    logic signed [31:0] shadow_tree [NODE_CNT];
    logic signed [31:0] shadow_fill;
    t_answer answer_q [$];
    int   error_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off_cycles = 0;
    longint cycle_cnt = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_cnt++;
    endtask

    function automatic logic signed [31:0] min_of(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [31:0] span_min(input int a, input int b, input int k,
                                                    input int l, input int r);
        int mid;
        if (r <= a || b <= l) return shadow_fill;
        if (a <= l && r <= b) return shadow_tree[k];
        mid = (l + r) / 2;
        return min_of(span_min(a, b, 2*k+1, l, mid), span_min(a, b, 2*k+2, mid, r));
    endfunction

    function automatic t_answer tree_apply(input logic [1:0] kind, input logic [6:0] idx,
                                           input logic signed [31:0] val,
                                           input logic [7:0] lo, input logic [7:0] hi);
        t_answer ans;
        int n;
        ans = '0;
        case (kind)
            REQ_UPDATE: begin
                n = int'(idx) + RMST_LEAVES - 1;
                shadow_tree[n] = val;
                while (n > 0) begin
                    n = (n - 1) / 2;
                    shadow_tree[n] = min_of(shadow_tree[2*n+1], shadow_tree[2*n+2]);
                end
            end
            REQ_QUERY: begin
                if (lo > hi) ans.range_error = 1'b1;
                else ans.min_value = span_min(int'(lo), int'(hi), 0, 0, RMST_LEAVES);
            end
            REQ_CLEAR: foreach (shadow_tree[i]) shadow_tree[i] = shadow_fill;
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: randomized ready, checks each accepted word against the oldest answer.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                rsp_bus.ready = 1'b0;
                hold_off_cycles--;
            end else begin
                rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected word", rsp_bus.min_value, '0);
            end else begin
                want = answer_q.pop_front();
                if (rsp_bus.min_value !== want.min_value)
                    report_mismatch("min_value", rsp_bus.min_value, want.min_value);
                if (rsp_bus.range_error !== want.range_error)
                    report_mismatch("range_error", 32'(rsp_bus.range_error),
                                    32'(want.range_error));
            end
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [6:0] idx,
                                input logic signed [31:0] val,
                                input logic [7:0] lo, input logic [7:0] hi);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        req_bus.valid      = 1'b1;
        req_bus.req_type   = kind;
        req_bus.leaf_index = idx;
        req_bus.leaf_value = val;
        req_bus.range_lo   = lo;
        req_bus.range_hi   = hi;
        do @(posedge i_clk); while (!req_bus.ready);
        answer_q.push_back(tree_apply(kind, idx, val, lo, hi));
        @(negedge i_clk);
        req_bus.valid = 1'b0;
    endtask

    task automatic drain_answers();
        while (answer_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_fill(input logic signed [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_FILL; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_fill = val;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed(32'($urandom_range(200))) - 100;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        int lo, hi, pick;
        repeat (count) begin
            pick = $urandom_range(99);
            lo = $urandom_range(128);
            hi = $urandom_range(128);
            if (pick < 8 && lo <= hi) begin
                lo = hi + 1;
                if (lo > 255) lo = 255;
            end else if (pick < 55 && lo > hi) begin
                {lo, hi} = {hi, lo};
            end
            if (pick < 55)
                send_request(REQ_QUERY, 7'($urandom), '0, 8'(lo), 8'(hi));
            else if (pick < 95)
                send_request(REQ_UPDATE, 7'($urandom), pick_value(), 8'($urandom),
                             8'($urandom));
            else if (pick < 97)
                send_request(REQ_CLEAR, 7'($urandom), pick_value(), 8'(lo), 8'(hi));
            else
                send_request(REQ_UNUSED, 7'($urandom), pick_value(), 8'(lo), 8'(hi));
        end
    endtask

    task automatic test_directed();
        send_request(REQ_QUERY, 7'd0, '0, 8'd0, 8'd128);
        send_request(REQ_UPDATE, 7'd0, 32'sh8000_0000, 8'd0, 8'd0);
        send_request(REQ_UPDATE, 7'd127, 32'sh7FFF_FFFE, 8'hFF, 8'hFF);
        send_request(REQ_UPDATE, 7'd64, -32'sd5, 8'd0, 8'd0);
        send_request(REQ_UPDATE, 7'd63, 32'sd9, 8'd0, 8'd0);
        send_request(REQ_QUERY, 7'd0, '0, 8'd0, 8'd128);
        send_request(REQ_QUERY, 7'd0, '0, 8'd1, 8'd128);
        send_request(REQ_QUERY, 7'd0, '0, 8'd63, 8'd64);
        send_request(REQ_QUERY, 7'd0, '0, 8'd64, 8'd64);
        send_request(REQ_QUERY, 7'd0, '0, 8'd128, 8'd128);
        send_request(REQ_QUERY, 7'd0, '0, 8'd100, 8'd255);
        send_request(REQ_QUERY, 7'd0, '0, 8'd200, 8'd255);
        send_request(REQ_QUERY, 7'd0, '0, 8'd5, 8'd4);
        send_request(REQ_QUERY, 7'd0, '0, 8'd255, 8'd0);
        send_request(REQ_UNUSED, 7'h7F, 32'shFFFF_FFFF, 8'hFF, 8'hFF);
        send_request(REQ_CLEAR, 7'd0, '0, 8'd0, 8'd0);
        send_request(REQ_QUERY, 7'd0, '0, 8'd0, 8'd128);
        drain_answers();
    endtask

    task automatic test_fill_settings();
        // The tree keeps old contents until a clear picks up the new fill.
        write_fill(32'sh8000_0000);
        send_random(20);
        send_request(REQ_CLEAR, 7'd0, '0, 8'd0, 8'd0);
        send_random(60);
        drain_answers();
        write_fill(32'sd0);
        send_request(REQ_CLEAR, 7'd0, '0, 8'd0, 8'd0);
        send_random(60);
        drain_answers();
        write_fill(32'sh7FFF_FFFF);
        send_request(REQ_CLEAR, 7'd0, '0, 8'd0, 8'd0);
        drain_answers();
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(250);
        send_idle_pct = 72; recv_stall_pct = 0;  send_random(200);
        send_idle_pct = 0;  recv_stall_pct = 72; send_random(200);
        send_idle_pct = 6;  recv_stall_pct = 6;  send_random(200);
        send_idle_pct = 0;  recv_stall_pct = 0;
        drain_answers();
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 400;
        send_random(120);
        drain_answers();
    endtask

    initial begin
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_UPDATE;
        req_bus.leaf_index = '0;
        req_bus.leaf_value = '0;
        req_bus.range_lo = '0;
        req_bus.range_hi = '0;
        shadow_fill = RESET_FILL;
        foreach (shadow_tree[i]) shadow_tree[i] = RESET_FILL;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_fill_settings();
        test_idle_phases();
        test_backpressure();
        if (error_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: range_min_segment_tree_unit.f
rtl/rmst_pkg.sv
rtl/rmst_req_if.sv
rtl/rmst_rsp_if.sv
rtl/rmst_ram.sv
rtl/rmst_ctrl.sv
rtl/rmst_dp.sv
rtl/range_min_segment_tree_unit.sv
rtl/rmst_chk.sv
sim/tb_top.sv
